[rtl/spm_idw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spm_idw_pkg
// Shared codes and defaults for the scattered point match / IDW core.
// ----------------------------------------------------------------------------
package spm_idw_pkg;

   localparam int MAX_POINTS_DEF  = 256;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int TOL_WIDTH = 16;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd2;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STAT_MATCH   = 3'd0,
      STAT_INTERP  = 3'd1,
      STAT_NOMATCH = 3'd2,
      STAT_LOADED  = 3'd3,
      STAT_FULL    = 3'd4,
      STAT_CLEARED = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      CSR_TOLERANCE = 2'd0,
      CSR_INTERP_EN = 2'd1
   } csr_index_type;

endpackage : spm_idw_pkg
`default_nettype wire

[rtl/scattered_point_match_idw_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scattered_point_match_idw_core
// Point table with tolerance match and inverse distance weighted fallback.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* stream carries one request: tuser = mode (load, query, clear),
//    tdata = x, y, value, grad_x, grad_y. Mode 3 is taken and dropped.
//  - rsp_* stream returns one result per load, clear or query:
//    tdata = value, grad_x, grad_y; tuser = status.
//  - csr_* write port: index 0 tolerance, index 1 interpolation enable.
// Sequencing (one request at a time, req_tready low while busy):
//  - load, clear: the result passes through ST_DONE into the rsp register;
//    the next request is taken only once the result is there.
//  - query, per scanned point: a match ends the scan; a point too far to
//    weigh is skipped; a squared distance of at most 1 or exactly 2^32 takes
//    a fixed weight, any other runs the 65-step weight division; each weighed
//    point adds four 32x32 partial products on the shared multiplier. With
//    interpolation on and a nonzero weight sum, a final division gives the answer.
//  - The core has a single restoring divider and a single 32x32 multiplier;
//    the table is read one entry per scanned point.
// Reset: point count cleared, tolerance = 2, interpolation off. Table
// contents are not cleared; only entries below the count are ever read.
// Stall: the result sits in the rsp register; a new request is taken while
// it waits, and the next result waits in the core until the slot frees.
// ----------------------------------------------------------------------------
module scattered_point_match_idw_core
   import spm_idw_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   // request stream
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata, low bit up: x_coord, y_coord, point_value, point_grad_x, point_grad_y
   input  wire logic [((2*COORD_WIDTH+3*VALUE_WIDTH+7)/8)*8-1:0] req_tdata,
   // tuser: mode
   input  wire logic [1:0] req_tuser,
   // response stream
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata, low bit up: result_value, result_grad_x, result_grad_y
   output logic [((3*VALUE_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // tuser: status
   output logic [2:0] rsp_tuser,
   // register writes
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [TOL_WIDTH-1:0] csr_wdata
);

   localparam int CW     = COORD_WIDTH;
   localparam int VW     = VALUE_WIDTH;
   localparam int EW     = 2*CW + 3*VW;
   localparam int RSP_DW = ((3*VW+7)/8)*8;
   localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNTW   = $clog2(MAX_POINTS+1);
   localparam int D2W    = 2*CW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_DIFF, ST_SQX, ST_SQY, ST_SUMD, ST_SQD, ST_WLOAD,
      ST_DIV, ST_PPM, ST_PPA, ST_NEXT, ST_FIN, ST_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [TOL_WIDTH-1:0] tol_ff;
   logic                 interp_ff;

   // table
   logic [EW-1:0]   mem_ff [MAX_POINTS];
   logic [EW-1:0]   rd_ff;
   logic [IW-1:0]   idx_ff;
   logic [CNTW-1:0] count_ff;
   logic            mem_we;

   // query working set
   logic [CW-1:0]  qx_ff, qy_ff;
   logic [CW-1:0]  dx_ff, dy_ff;
   logic [D2W-1:0] d2_ff;
   logic [63:0]    prod_ff;
   logic [63:0]    w_ff;
   logic [63:0]    mag_ff;
   logic           vneg_ff;
   logic [1:0]     pp_ff;
   logic [127:0]   acc_pos_ff, acc_neg_ff, wsum_ff;
   logic           qneg_ff;

   // divider
   logic [127:0] num_ff, den_ff, rem_ff, quo_ff;
   logic [7:0]   cnt_ff;
   logic         final_ff;

   // pending result
   logic [VW-1:0] res_v_ff, res_gx_ff, res_gy_ff;
   logic [2:0]    res_st_ff;

   // response register
   logic          rsp_valid_ff;
   logic [VW-1:0] rsp_v_ff, rsp_gx_ff, rsp_gy_ff;
   logic [2:0]    rsp_st_ff;

   logic     req_fire;
   mode_type req_mode;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_mode   = mode_type'(req_tuser);
   assign mem_we     = req_fire && (req_mode == MODE_LOAD) &&
                       (count_ff < CNTW'(MAX_POINTS));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'({rsp_gy_ff, rsp_gx_ff, rsp_v_ff});
   assign rsp_tuser  = rsp_st_ff;

   // table entry fields
   logic [CW-1:0] e_x, e_y;
   logic [VW-1:0] e_v, e_gx, e_gy;
   assign e_x  = rd_ff[CW-1:0];
   assign e_y  = rd_ff[2*CW-1:CW];
   assign e_v  = rd_ff[2*CW+VW-1:2*CW];
   assign e_gx = rd_ff[2*CW+2*VW-1:2*CW+VW];
   assign e_gy = rd_ff[EW-1:2*CW+2*VW];

   // per-axis distance and window test
   logic signed [CW:0] sdx, sdy;
   logic [CW:0]        adx, ady;
   logic [CW-1:0]      dx, dy;
   logic               in_window;
   logic [VW-1:0]      e_mag;
   assign sdx = $signed({e_x[CW-1], e_x}) - $signed({qx_ff[CW-1], qx_ff});
   assign sdy = $signed({e_y[CW-1], e_y}) - $signed({qy_ff[CW-1], qy_ff});
   assign adx = sdx[CW] ? (CW+1)'(-sdx) : sdx;
   assign ady = sdy[CW] ? (CW+1)'(-sdy) : sdy;
   assign dx  = adx[CW-1:0];
   assign dy  = ady[CW-1:0];
   assign in_window = ({{TOL_WIDTH{1'b0}}, dx} < {{CW{1'b0}}, tol_ff}) &&
                      ({{TOL_WIDTH{1'b0}}, dy} < {{CW{1'b0}}, tol_ff});
   assign e_mag = e_v[VW-1] ? VW'(-e_v) : e_v;

   // shared 32x32 multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   always_comb begin
      case (state_ff)
         ST_SQX: begin
            mul_a = 32'(dx_ff);
            mul_b = 32'(dx_ff);
         end
         ST_SQY: begin
            mul_a = 32'(dy_ff);
            mul_b = 32'(dy_ff);
         end
         ST_SQD: begin
            mul_a = 32'(d2_ff);
            mul_b = 32'(d2_ff);
         end
         ST_PPM: begin
            mul_a = pp_ff[1] ? w_ff[63:32] : w_ff[31:0];
            mul_b = pp_ff[0] ? mag_ff[63:32] : mag_ff[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // squared distance and weight special cases
   logic [D2W-1:0] d2_sum;
   logic           d2_tiny, d2_over, d2_edge;
   assign d2_sum  = d2_ff + D2W'(prod_ff);
   assign d2_tiny = (d2_sum <= D2W'(1));
   assign d2_over = (64'(d2_sum) > 64'h0000_0001_0000_0000);
   assign d2_edge = (64'(d2_sum) == 64'h0000_0001_0000_0000);

   // partial product placed at its 32-bit column
   logic [127:0] pp_term;
   always_comb begin
      case (2'(pp_ff[1]) + 2'(pp_ff[0]))
         2'd0:    pp_term = 128'(prod_ff);
         2'd1:    pp_term = 128'(prod_ff) << 32;
         default: pp_term = 128'(prod_ff) << 64;
      endcase
   end

   // restoring divider step
   logic [128:0] rem_sh;
   logic         div_ge;
   logic [127:0] rem_nx, quo_nx;
   assign rem_sh = {rem_ff, num_ff[127]};
   assign div_ge = (rem_sh >= {1'b0, den_ff});
   assign rem_nx = div_ge ? 128'(rem_sh - {1'b0, den_ff}) : rem_sh[127:0];
   assign quo_nx = {quo_ff[126:0], div_ge};

   // quotient saturation to the signed value range
   logic [127:0] lim;
   logic [127:0] q_sat;
   logic [VW-1:0] q_val;
   assign lim   = (128'(1) << (VW-1)) - 128'(!qneg_ff);
   assign q_sat = (quo_nx > lim) ? lim : quo_nx;
   assign q_val = qneg_ff ? VW'(-q_sat[VW-1:0]) : q_sat[VW-1:0];

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[count_ff[IW-1:0]] <= req_tdata[EW-1:0];
      end
      rd_ff <= mem_ff[idx_ff];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff    <= TOL_RESET;
         interp_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TOLERANCE: tol_ff    <= csr_wdata;
            CSR_INTERP_EN: interp_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         // ST_DONE reloads the slot itself
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  res_v_ff  <= '0;
                  res_gx_ff <= '0;
                  res_gy_ff <= '0;
                  qx_ff     <= req_tdata[CW-1:0];
                  qy_ff     <= req_tdata[2*CW-1:CW];
                  case (req_mode)
                     MODE_LOAD: begin
                        if (mem_we) begin
                           count_ff  <= count_ff + CNTW'(1);
                           res_st_ff <= STAT_LOADED;
                        end else begin
                           res_st_ff <= STAT_FULL;
                        end
                        state_ff <= ST_DONE;
                     end
                     MODE_CLEAR: begin
                        count_ff  <= '0;
                        res_st_ff <= STAT_CLEARED;
                        state_ff  <= ST_DONE;
                     end
                     MODE_QUERY: begin
                        idx_ff     <= '0;
                        acc_pos_ff <= '0;
                        acc_neg_ff <= '0;
                        wsum_ff    <= '0;
                        res_st_ff  <= STAT_NOMATCH;
                        state_ff   <= (count_ff == '0) ? ST_DONE : ST_READ;
                     end
                     default: ;
                  endcase
               end
            end
            ST_READ: state_ff <= ST_DIFF;
            ST_DIFF: begin
               if (in_window) begin
                  res_v_ff  <= e_v;
                  res_gx_ff <= e_gx;
                  res_gy_ff <= e_gy;
                  res_st_ff <= STAT_MATCH;
                  state_ff  <= ST_DONE;
               end else begin
                  dx_ff    <= dx;
                  dy_ff    <= dy;
                  vneg_ff  <= e_v[VW-1];
                  mag_ff   <= 64'(e_mag);
                  state_ff <= ST_SQX;
               end
            end
            ST_SQX: begin
               prod_ff  <= mul_p;
               state_ff <= ST_SQY;
            end
            ST_SQY: begin
               d2_ff    <= D2W'(prod_ff);
               prod_ff  <= mul_p;
               state_ff <= ST_SUMD;
            end
            ST_SUMD: begin
               d2_ff <= d2_sum;
               pp_ff <= '0;
               if (d2_tiny) begin
                  w_ff     <= '1;
                  state_ff <= ST_PPM;
               end else if (d2_over) begin
                  state_ff <= ST_NEXT;
               end else if (d2_edge) begin
                  w_ff     <= 64'd1;
                  state_ff <= ST_PPM;
               end else begin
                  state_ff <= ST_SQD;
               end
            end
            ST_SQD: begin
               prod_ff  <= mul_p;
               state_ff <= ST_WLOAD;
            end
            ST_WLOAD: begin
               // 2^64 / d^4: dividend 2^64 enters MSB first over 65 steps
               num_ff   <= {1'b1, 127'd0};
               den_ff   <= 128'(prod_ff);
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= 8'd65;
               final_ff <= 1'b0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               num_ff <= {num_ff[126:0], 1'b0};
               rem_ff <= rem_nx;
               quo_ff <= quo_nx;
               cnt_ff <= cnt_ff - 8'd1;
               if (cnt_ff == 8'd1) begin
                  if (final_ff) begin
                     res_v_ff  <= q_val;
                     res_st_ff <= STAT_INTERP;
                     state_ff  <= ST_DONE;
                  end else begin
                     w_ff     <= quo_nx[63:0];
                     pp_ff    <= '0;
                     state_ff <= ST_PPM;
                  end
               end
            end
            ST_PPM: begin
               prod_ff  <= mul_p;
               state_ff <= ST_PPA;
            end
            ST_PPA: begin
               if (vneg_ff) begin
                  acc_neg_ff <= acc_neg_ff + pp_term;
               end else begin
                  acc_pos_ff <= acc_pos_ff + pp_term;
               end
               if (pp_ff == 2'd0) begin
                  wsum_ff <= wsum_ff + 128'(w_ff);
               end
               pp_ff    <= pp_ff + 2'd1;
               state_ff <= (pp_ff == 2'd3) ? ST_NEXT : ST_PPM;
            end
            ST_NEXT: begin
               idx_ff <= idx_ff + IW'(1);
               if ((CNTW'(idx_ff) + CNTW'(1)) == count_ff) begin
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_FIN: begin
               if (!interp_ff || (wsum_ff == '0)) begin
                  state_ff <= ST_DONE;
               end else begin
                  qneg_ff  <= (acc_pos_ff < acc_neg_ff);
                  num_ff   <= (acc_pos_ff < acc_neg_ff) ? acc_neg_ff - acc_pos_ff
                                                        : acc_pos_ff - acc_neg_ff;
                  den_ff   <= wsum_ff;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= 8'd128;
                  final_ff <= 1'b1;
                  state_ff <= ST_DIV;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_v_ff     <= res_v_ff;
                  rsp_gx_ff    <= res_gx_ff;
                  rsp_gy_ff    <= res_gy_ff;
                  rsp_st_ff    <= res_st_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_POINTS))
      else $error("point count beyond table depth");

   a_load_counts: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> count_ff == CNTW'($past(count_ff) + CNTW'(1)))
      else $error("load did not advance point count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_mode == MODE_CLEAR) |=> count_ff == '0)
      else $error("clear left points in table");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff != 8'd0)
      else $error("divider running with zero step count");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_DONE)
      else $error("pending result dropped while output stalled");

endmodule : scattered_point_match_idw_core
`default_nettype wire
